FILE: design/csac_pkg.sv
// Shared types, constants and codes for the coherent set-associative cache lookup.
package csac_pkg;

  localparam int ADDR_BITS    = 32;
  localparam int OFFSET_BITS  = 4;
  localparam int INDEX_BITS   = 6;
  localparam int TAG_BITS     = ADDR_BITS - OFFSET_BITS - INDEX_BITS;
  localparam int NUM_SETS     = 1 << INDEX_BITS;
  localparam int DEF_MAX_WAYS = 4;
  localparam int CFG_DATA_W   = 3;

  localparam logic [1:0] CMD_LOAD        = 2'd0;
  localparam logic [1:0] CMD_STORE       = 2'd1;
  localparam logic [1:0] CMD_SNOOP_LOAD  = 2'd2;
  localparam logic [1:0] CMD_SNOOP_STORE = 2'd3;

  localparam logic [1:0] PROTO_NONE = 2'd0;
  localparam logic [1:0] PROTO_VI   = 2'd1;
  localparam logic [1:0] PROTO_MSI  = 2'd2;

  localparam logic [1:0] ST_INVALID  = 2'd0;
  localparam logic [1:0] ST_VALID    = 2'd1;
  localparam logic [1:0] ST_SHARED   = 2'd2;
  localparam logic [1:0] ST_MODIFIED = 2'd3;

  localparam logic REG_PROTOCOL_MODE = 1'b0;
  localparam logic REG_WAYS_IN_USE   = 1'b1;

  localparam logic [2:0] WAYS_RESET = 3'd4;

  typedef logic cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] address;
  } csac_in_t;

  typedef struct packed {
    logic       hit;
    logic       writeback;
    logic       upgrade_miss;
    logic       snoop_seen;
    logic       snoop_hit;
    logic [1:0] way_used;
    logic [5:0] set_used;
  } csac_out_t;

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [1:0]          state;
    logic                dirty;
  } line_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [1:0] proto;
    logic       hit;
  } upd_ctl_t;

  typedef struct packed {
    logic wb;
    logic upg;
  } upd_flags_t;

endpackage

FILE: design/csac_line_upd.sv
// Next-state logic for one cache line: fill, store hit and snoop transitions.
module csac_line_upd (
  input  csac_pkg::upd_ctl_t                 ctl,
  input  logic [csac_pkg::TAG_BITS-1:0]      tag_i,
  input  csac_pkg::line_t                    line_i,
  output csac_pkg::line_t                    line_o,
  output csac_pkg::upd_flags_t               flags
);
  import csac_pkg::*;

  logic is_local;
  logic is_store;
  logic is_msi;

  assign is_local = (ctl.cmd == CMD_LOAD) || (ctl.cmd == CMD_STORE);
  assign is_store = (ctl.cmd == CMD_STORE);
  assign is_msi   = (ctl.proto == PROTO_MSI);

  always_comb begin
    line_o = line_i;
    flags  = '0;
    if (is_local) begin
      if (ctl.hit) begin
        if (is_store) begin
          flags.upg    = is_msi && (line_i.state == ST_SHARED);
          line_o.dirty = 1'b1;
          if (is_msi) begin
            line_o.state = ST_MODIFIED;
          end
        end
      end else begin
        flags.wb     = (line_i.state != ST_INVALID) && line_i.dirty;
        line_o.tag   = tag_i;
        line_o.dirty = is_store;
        if (is_msi) begin
          line_o.state = is_store ? ST_MODIFIED : ST_SHARED;
        end else begin
          line_o.state = ST_VALID;
        end
      end
    end else if (ctl.hit) begin
      unique case (ctl.proto)
        PROTO_VI: begin
          if (line_i.state == ST_VALID) begin
            line_o.state = ST_INVALID;
            line_o.dirty = 1'b0;
            flags.wb     = line_i.dirty;
          end
        end
        PROTO_MSI: begin
          if (ctl.cmd == CMD_SNOOP_LOAD) begin
            if (line_i.state == ST_MODIFIED) begin
              line_o.state = ST_SHARED;
              line_o.dirty = 1'b0;
              flags.wb     = 1'b1;
            end
          end else begin
            flags.wb     = (line_i.state == ST_MODIFIED);
            line_o.state = ST_INVALID;
            line_o.dirty = 1'b0;
          end
        end
        default: begin
          line_o = line_i;
        end
      endcase
    end
  end

endmodule

FILE: design/coherent_set_assoc_cache_lookup.sv
// Top level: set-associative tag/state controller with one shared tag comparator.
// Flow: a taken request reads its set row into a register; the scan then compares
//   one way a cycle, from way 0 to the hit way or the last way in use; the update
//   step writes the row back and registers the result, and holds while the result
//   slot is full. No new request is taken until the update step is done.
// Reset: per-set row valid bits clear at once, so every line reads invalid and every
//   replace pointer zero; protocol_mode resets to none and ways_in_use to 4.
module coherent_set_assoc_cache_lookup #(
  parameter int MAX_WAYS = csac_pkg::DEF_MAX_WAYS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  csac_pkg::csac_in_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output csac_pkg::csac_out_t   out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  csac_pkg::cfg_idx_t    cfg_index,
  input  csac_pkg::cfg_data_t   cfg_data
);
  import csac_pkg::*;

  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int CNT_W = $clog2(MAX_WAYS + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_UPDATE = 2'd2;

  typedef struct packed {
    logic [WAY_W-1:0]          ptr;
    line_t [MAX_WAYS-1:0]      lines;
  } row_t;

  row_t                  row_mem [NUM_SETS];
  logic [NUM_SETS-1:0]   row_vld_r;
  row_t                  row_rd_r;
  logic                  rowv_rd_r;

  logic [1:0]            state_r;
  logic [1:0]            state_nxt;
  logic [1:0]            cmd_r;
  logic [TAG_BITS-1:0]   tag_r;
  logic [INDEX_BITS-1:0] set_r;
  logic [WAY_W-1:0]      w_r;
  logic [WAY_W-1:0]      w_nxt;
  logic                  hit_r;
  logic                  hit_nxt;
  logic [1:0]            proto_r;
  logic [2:0]            ways_cfg_r;
  logic                  out_valid_r;
  csac_out_t             out_r;

  logic                  in_fire;
  logic                  upd_go;
  logic [CNT_W-1:0]      ways_eff;
  logic [CNT_W:0]        ways_ext;
  logic [CNT_W:0]        w_inc;
  logic                  last_way;
  row_t                  row_eff;
  line_t                 cur_line;
  logic                  tag_match;
  logic [WAY_W-1:0]      victim;
  logic [WAY_W-1:0]      ptr_new;
  logic                  is_local;
  row_t                  row_new;
  upd_ctl_t              upd_ctl;
  line_t                 upd_line;
  upd_flags_t            upd_flags;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proto_r    <= PROTO_NONE;
      ways_cfg_r <= WAYS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PROTOCOL_MODE: proto_r    <= cfg_data[1:0];
        REG_WAYS_IN_USE:   ways_cfg_r <= cfg_data;
      endcase
    end
  end

  always_comb begin
    if (ways_cfg_r == 3'd0) begin
      ways_eff = CNT_W'(1);
    end else if (int'(ways_cfg_r) > MAX_WAYS) begin
      ways_eff = CNT_W'(MAX_WAYS);
    end else begin
      ways_eff = CNT_W'(ways_cfg_r);
    end
  end

  assign ways_ext = (CNT_W + 1)'(ways_eff);
  assign w_inc    = (CNT_W + 1)'(w_r) + (CNT_W + 1)'(1);
  assign last_way = (w_inc == ways_ext);
  assign ptr_new  = last_way ? '0 : WAY_W'(w_inc);

  assign row_eff   = rowv_rd_r ? row_rd_r : '0;
  assign cur_line  = row_eff.lines[w_r];
  assign tag_match = (cur_line.state != ST_INVALID) && (cur_line.tag == tag_r);
  assign victim    = ((CNT_W + 1)'(row_eff.ptr) >= ways_ext) ? '0 : row_eff.ptr;
  assign is_local  = !cmd_r[1];

  assign upd_ctl.cmd   = cmd_r;
  assign upd_ctl.proto = proto_r;
  assign upd_ctl.hit   = hit_r;

  csac_line_upd u_line_upd (
    .ctl    (upd_ctl),
    .tag_i  (tag_r),
    .line_i (cur_line),
    .line_o (upd_line),
    .flags  (upd_flags)
  );

  always_comb begin
    row_new            = row_eff;
    row_new.lines[w_r] = upd_line;
    if (is_local) begin
      row_new.ptr = ptr_new;
    end
  end

  assign upd_go = (state_r == S_UPDATE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    w_nxt     = w_r;
    hit_nxt   = hit_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_SCAN;
          w_nxt     = '0;
          hit_nxt   = 1'b0;
        end
      end
      S_SCAN: begin
        if (tag_match) begin
          hit_nxt   = 1'b1;
          state_nxt = S_UPDATE;
        end else if (last_way) begin
          w_nxt     = victim;
          state_nxt = S_UPDATE;
        end else begin
          w_nxt = WAY_W'(w_inc);
        end
      end
      S_UPDATE: begin
        if (upd_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      w_r     <= '0;
      hit_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      w_r     <= w_nxt;
      hit_r   <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= in_data.command;
      tag_r <= in_data.address[ADDR_BITS-1 -: TAG_BITS];
      set_r <= in_data.address[OFFSET_BITS +: INDEX_BITS];
    end
  end

  // set memory: one row per set, registered read at request, write at update
  always_ff @(posedge clk) begin
    if (in_fire) begin
      row_rd_r <= row_mem[in_data.address[OFFSET_BITS +: INDEX_BITS]];
    end
    if (upd_go) begin
      row_mem[set_r] <= row_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rowv_rd_r <= 1'b0;
    end else begin
      if (in_fire) begin
        rowv_rd_r <= row_vld_r[in_data.address[OFFSET_BITS +: INDEX_BITS]];
      end
      if (upd_go) begin
        row_vld_r[set_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (upd_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      out_r.hit          <= hit_r;
      out_r.writeback    <= upd_flags.wb;
      out_r.upgrade_miss <= upd_flags.upg;
      out_r.snoop_seen   <= !is_local;
      out_r.snoop_hit    <= !is_local && hit_r;
      out_r.way_used     <= is_local ? 2'(w_r) : 2'd0;
      out_r.set_used     <= 6'(set_r);
    end
  end

`ifndef SYNTH
  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_SCAN)
    else $error("request accepted without starting the way scan");

  a_result_from_update: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_UPDATE)
    else $error("result raised outside the update step");

  a_update_holds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UPDATE && out_valid_r && !out_ready |=> state_r == S_UPDATE)
    else $error("update left while the result slot was full");

  a_upgrade_local_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.upgrade_miss |-> out_r.hit && !out_r.snoop_seen)
    else $error("upgrade flagged on a miss or a snoop");
`endif

endmodule
